>>> src/sha1sh_pkg.sv
// Shared types, constants and round functions for the SHA-1 stream hash core.
// No dependencies; imported by every module in src.
package sha1sh_pkg;

    localparam int unsigned NUM_CELLS  = 16;
    localparam int unsigned NUM_ROUNDS = 80;
    localparam int unsigned NUM_WORDS  = 5;

    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] H_INIT [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    // what each schedule cell does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_BYTE,
        CELL_WORD
    } cell_mode_t;

    // controls from the sequencer to the round datapath
    typedef struct packed {
        logic load;
        logic step;
        logic fold;
        logic restart;
    } rnd_ctl_t;

    function automatic logic [31:0] rnd_f(input logic [31:0] b, input logic [31:0] c,
                                          input logic [31:0] d, input logic [6:0] t);
        logic [31:0] r;
        if (t < 7'd20) begin
            r = (b & c) | (~b & d);
        end else if (t < 7'd40) begin
            r = b ^ c ^ d;
        end else if (t < 7'd60) begin
            r = (b & c) | (b & d) | (c & d);
        end else begin
            r = b ^ c ^ d;
        end
        return r;
    endfunction

    function automatic logic [31:0] rnd_k(input logic [6:0] t);
        logic [31:0] r;
        if (t < 7'd20) begin
            r = K_R0;
        end else if (t < 7'd40) begin
            r = K_R1;
        end else if (t < 7'd60) begin
            r = K_R2;
        end else begin
            r = K_R3;
        end
        return r;
    endfunction

endpackage

>>> src/sha1_stream_hash_core.sv
// SHA-1 stream hash core: top level with the byte/padding sequencer.
// Depends on sha1sh_pkg, sha1sh_cell and sha1sh_round.
//
// Usage:
//   Input channel s_*: one word per handshake. s_tdata carries a message byte,
//   s_tuser marks it as a real byte (0 = no byte, e.g. to close an empty
//   message), s_tlast ends the message.
//   Output channel m_*: the five 32-bit digest words h0..h4, big-endian value,
//   m_tlast set on h4.
// Flow:
//   A byte word is taken whenever the core is idle. Every 64th byte starts a
//   compression (80 rounds of the single round unit and a fold; the load
//   overlaps the 64th byte) during which s_tready is low. At message end the
//   padding bytes are shifted into the cell chain one per cycle, bar an empty
//   ST_PADZ pass before the length (up to 64 bytes, or 72 for two blocks),
//   each block followed by its compression; then the digest is offered.
// Reset: aresetn (synchronous, active low) restores the initial chain value,
//   zeroes the bit count and fill position; the block buffer is not cleared.
// Stall: while m_tready is low the current digest word is held and no input
//   is taken; a new message starts only after the fifth word is taken.
module sha1_stream_hash_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic        m_tlast
);
    import sha1sh_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_PADLEN,
        ST_ROUNDS,
        ST_FOLD,
        ST_EMIT
    } state_t;

    state_t      state_reg, ret_reg;
    logic [5:0]  fill_reg;
    logic [63:0] bit_count_reg;
    logic [6:0]  round_reg;
    logic [2:0]  word_idx_reg;

    cell_mode_t  cell_mode;
    logic [7:0]  push_byte;
    logic [5:0]  fill_next;
    rnd_ctl_t    ctl;
    logic [31:0] w_q [NUM_CELLS];
    logic [31:0] w_new;
    logic [31:0] w_mix;
    logic [31:0] h_word;
    logic        last_word;

    assign fill_next = fill_reg + 6'd1;
    assign w_mix     = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    assign w_new     = {w_mix[30:0], w_mix[31]};
    assign last_word = (word_idx_reg == 3'(NUM_WORDS - 1));

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = h_word;
    assign m_tlast  = last_word;

    always_comb begin
        cell_mode = CELL_HOLD;
        push_byte = '0;
        ctl       = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tuser) begin
                    cell_mode = CELL_BYTE;
                    push_byte = s_tdata;
                    ctl.load  = (fill_next == 6'd0);
                end
            end
            ST_PAD80: begin
                cell_mode = CELL_BYTE;
                push_byte = PAD_BYTE;
                ctl.load  = (fill_next == 6'd0);
            end
            ST_PADZ: begin
                if (fill_reg != LEN_POS) begin
                    cell_mode = CELL_BYTE;
                    ctl.load  = (fill_next == 6'd0);
                end
            end
            ST_PADLEN: begin
                // length goes out most significant byte first
                cell_mode = CELL_BYTE;
                push_byte = bit_count_reg[{~fill_reg[2:0], 3'b000} +: 8];
                ctl.load  = (fill_next == 6'd0);
            end
            ST_ROUNDS: begin
                cell_mode = CELL_WORD;
                ctl.step  = 1'b1;
            end
            ST_FOLD: begin
                ctl.fold = 1'b1;
            end
            ST_EMIT: begin
                ctl.restart = m_tready && last_word;
            end
            default: begin
                cell_mode = CELL_HOLD;
            end
        endcase
    end

    // schedule chain: bytes enter at the tail cell, words move toward cell 0
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        if (i == NUM_CELLS - 1) begin : g_tail
            sha1sh_cell u_cell (
                .aclk    (aclk),
                .mode    (cell_mode),
                .byte_in (push_byte),
                .word_in (w_new),
                .word_q  (w_q[i])
            );
        end else begin : g_body
            sha1sh_cell u_cell (
                .aclk    (aclk),
                .mode    (cell_mode),
                .byte_in (w_q[i+1][31:24]),
                .word_in (w_q[i+1]),
                .word_q  (w_q[i])
            );
        end
    end

    sha1sh_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .round_idx (round_reg),
        .w         (w_q[0]),
        .word_sel  (word_idx_reg),
        .h_word    (h_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            fill_reg      <= '0;
            bit_count_reg <= '0;
            round_reg     <= '0;
            word_idx_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser) begin
                            fill_reg      <= fill_next;
                            bit_count_reg <= bit_count_reg + 64'd8;
                            if (fill_next == 6'd0) begin
                                ret_reg   <= s_tlast ? ST_PAD80 : ST_IDLE;
                                state_reg <= ST_ROUNDS;
                            end else if (s_tlast) begin
                                state_reg <= ST_PAD80;
                            end
                        end else if (s_tlast) begin
                            state_reg <= ST_PAD80;
                        end
                    end
                end
                ST_PAD80: begin
                    fill_reg <= fill_next;
                    if (fill_next == 6'd0) begin
                        ret_reg   <= ST_PADZ;
                        state_reg <= ST_ROUNDS;
                    end else if (fill_next == LEN_POS) begin
                        state_reg <= ST_PADLEN;
                    end else begin
                        state_reg <= ST_PADZ;
                    end
                end
                ST_PADZ: begin
                    if (fill_reg == LEN_POS) begin
                        state_reg <= ST_PADLEN;
                    end else begin
                        fill_reg <= fill_next;
                        if (fill_next == 6'd0) begin
                            ret_reg   <= ST_PADZ;
                            state_reg <= ST_ROUNDS;
                        end
                    end
                end
                ST_PADLEN: begin
                    fill_reg <= fill_next;
                    if (fill_next == 6'd0) begin
                        ret_reg   <= ST_EMIT;
                        state_reg <= ST_ROUNDS;
                    end
                end
                ST_ROUNDS: begin
                    round_reg <= round_reg + 7'd1;
                    if (round_reg == 7'(NUM_ROUNDS - 1)) begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    round_reg    <= '0;
                    word_idx_reg <= '0;
                    state_reg    <= ret_reg;
                end
                ST_EMIT: begin
                    if (m_tready) begin
                        if (last_word) begin
                            state_reg     <= ST_IDLE;
                            fill_reg      <= '0;
                            bit_count_reg <= '0;
                            word_idx_reg  <= '0;
                        end else begin
                            word_idx_reg <= word_idx_reg + 3'd1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/sha1sh_cell.sv
// One 32-bit cell of the block buffer / message schedule chain.
// Depends on sha1sh_pkg for the cell mode type.
module sha1sh_cell (
    input  logic                   aclk,
    input  sha1sh_pkg::cell_mode_t mode,
    input  logic [7:0]             byte_in,   // top byte of the next cell, or fresh byte
    input  logic [31:0]            word_in,   // next cell, or fresh schedule word
    output logic [31:0]            word_q
);
    import sha1sh_pkg::*;

    logic [31:0] word_reg;

    always_ff @(posedge aclk) begin
        unique case (mode)
            CELL_BYTE: word_reg <= {word_reg[23:0], byte_in};
            CELL_WORD: word_reg <= word_in;
            default:   word_reg <= word_reg;
        endcase
    end

    assign word_q = word_reg;

endmodule

>>> src/sha1sh_round.sv
// SHA-1 round datapath: working variables a..e and the chain value h0..h4.
// Depends on sha1sh_pkg for round functions, constants and the control struct.
module sha1sh_round (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sha1sh_pkg::rnd_ctl_t ctl,
    input  logic [6:0]           round_idx,
    input  logic [31:0]          w,
    input  logic [2:0]           word_sel,
    output logic [31:0]          h_word
);
    import sha1sh_pkg::*;

    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] h_reg [NUM_WORDS];
    logic [31:0] a_next;

    assign a_next = {a_reg[26:0], a_reg[31:27]} + rnd_f(b_reg, c_reg, d_reg, round_idx)
                  + e_reg + rnd_k(round_idx) + w;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end else if (ctl.step) begin
            a_reg <= a_next;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.restart) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                h_reg[i] <= H_INIT[i];
            end
        end else if (ctl.fold) begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
        end
    end

    always_comb begin
        unique case (word_sel)
            3'd0:    h_word = h_reg[0];
            3'd1:    h_word = h_reg[1];
            3'd2:    h_word = h_reg[2];
            3'd3:    h_word = h_reg[3];
            default: h_word = h_reg[4];
        endcase
    end

endmodule

>>> tb/testbench.sv
// Self-checking bench for sha1_stream_hash_core: byte words in, five digest words out.
// Depends on sha1sh_pkg (constants) and the core RTL. It keeps a SHA-1 model of
// its own and checks every digest word in order.
module testbench;
    import sha1sh_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_WORDS  = 20;    // no idling once this few words are left to send
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN       = 300;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       ends;
    } stim_word_t;

    typedef struct {
        logic [31:0] word;
        logic        last;
    } digest_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    sha1_stream_hash_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------- SHA-1 model state ----------------
    logic [7:0]  blk   [64];
    logic [31:0] chain [5];
    logic [63:0] nbits;
    logic [5:0]  fill;

    stim_word_t stim_q [$];
    digest_t    digest_words_due [$];

    int msg_count     = 0;
    int byte_count    = 0;
    int empty_finish  = 0;
    int idle_count    = 0;
    int words_checked = 0;
    int fail_count    = 0;
    int digests_done  = 0;
    int cycles        = 0;
    logic calm        = 1'b0;

    function automatic logic [31:0] rotl32(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 5; i++) chain[i] = H_INIT[i];
        nbits = '0;
        fill  = '0;
    endfunction

    function automatic void sha1_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, nxt;
        for (int t = 0; t < 16; t++)
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        for (int t = 16; t < 80; t++)
            w[t] = rotl32(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int t = 0; t < 80; t++) begin
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K_R0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_R1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_R2;
            end else begin
                f = b ^ c ^ d;
                k = K_R3;
            end
            nxt = rotl32(a, 5) + f + e + k + w[t];
            e = d; d = c; c = rotl32(b, 30); b = a; a = nxt;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    // fold one accepted word into the hash; a finishing word queues the digest
    function automatic void sha1_absorb(stim_word_t sw);
        digest_t dw;
        int p;
        if (sw.has_byte) begin
            blk[fill] = sw.data;
            nbits += 64'd8;
            fill += 6'd1;
            if (fill == 6'd0) sha1_compress();
        end
        if (sw.ends) begin
            p = int'(fill);
            blk[p] = PAD_BYTE;
            p++;
            if (p > LEN_POS) begin
                // 0x80 landed too late for the length: extra block
                while (p < 64) begin
                    blk[p] = 8'h00;
                    p++;
                end
                sha1_compress();
                p = 0;
            end
            while (p < LEN_POS) begin
                blk[p] = 8'h00;
                p++;
            end
            for (int i = 0; i < 8; i++) blk[LEN_POS + i] = nbits[63 - 8*i -: 8];
            sha1_compress();
            for (int i = 0; i < 5; i++) begin
                dw.word = chain[i];
                dw.last = (i == 4);
                digest_words_due.insert(digest_words_due.size(), dw);
            end
            restart_hash();
        end
    endfunction

    // ---------------- stimulus build ----------------
    function automatic void push_word(logic [7:0] data, logic has_byte, logic ends);
        stim_word_t sw;
        sw.data     = data;
        sw.has_byte = has_byte;
        sw.ends     = ends;
        stim_q.insert(stim_q.size(), sw);
        if (has_byte) byte_count++;
        if (!has_byte && ends) empty_finish++;
        if (!has_byte && !ends) idle_count++;
    endfunction

    // random content; the final word carries the last byte or none
    function automatic void add_message(int len, bit end_on_byte);
        int n;
        n = (len == 0) ? 0 : (end_on_byte ? len - 1 : len);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) push_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
        if (len != 0 && end_on_byte)
            push_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        else
            push_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        msg_count++;
    endfunction

    initial begin
        int len;
        restart_hash();
        for (int i = 0; i < 64; i++) blk[i] = 8'h00;

        // directed: empty message, single extreme bytes, "abc", close by empty word
        push_word(8'h3c, 1'b0, 1'b1);
        push_word(8'h00, 1'b1, 1'b1);
        push_word(8'hff, 1'b1, 1'b1);
        push_word(8'ha5, 1'b0, 1'b0);
        push_word(8'h61, 1'b1, 1'b0);
        push_word(8'h62, 1'b1, 1'b0);
        push_word(8'h63, 1'b1, 1'b1);
        push_word(8'h61, 1'b1, 1'b0);
        push_word(8'h5a, 1'b0, 1'b0);
        push_word(8'h62, 1'b1, 1'b0);
        push_word(8'hc3, 1'b0, 1'b1);
        push_word(8'h80, 1'b1, 1'b0);
        push_word(8'h7f, 1'b1, 1'b0);
        push_word(8'h00, 1'b0, 1'b1);
        msg_count += 6;

        // one message near the padding and block edges, then short random messages
        len = $urandom_range(55, 64);
        add_message(len, 1'($urandom_range(0, 1)));
        for (int m = 0; m < 5; m++) begin
            len = $urandom_range(0, 8);
            add_message(len, (len != 0) && ($urandom_range(0, 1) != 0));
        end
        // trailing idle words: they must produce nothing
        push_word(8'hee, 1'b0, 1'b0);
        push_word(8'h11, 1'b0, 1'b0);
    end

    // ---------------- reset ----------------
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ---------------- input driver ----------------
    int gap_left = 0;

    always @(posedge aclk) begin : drive_in
        stim_word_t sw;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            calm <= (stim_q.size() < TAIL_WORDS);
            if (!s_tvalid || s_tready) begin
                if (s_tvalid) begin
                    sw.data     = s_tdata;
                    sw.has_byte = s_tuser;
                    sw.ends     = s_tlast;
                    sha1_absorb(sw);
                end
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (stim_q.size() != 0) begin
                    sw = stim_q.pop_front();
                    s_tdata  <= sw.data;
                    s_tuser  <= sw.has_byte;
                    s_tlast  <= sw.ends;
                    s_tvalid <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 18);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- output ready ----------------
    int  stall_left = 0;
    bit  long_done  = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!long_done && m_tvalid && digests_done >= 2) begin
            // sender keeps offering; the core must back up and drop s_tready
            long_done  <= 1'b1;
            stall_left <= LONG_HOLD - 1;
            m_tready   <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 17);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------- digest checker ----------------
    always @(posedge aclk) begin : check_out
        digest_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            words_checked++;
            if (digest_words_due.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected digest word %h last %b", m_tdata, m_tlast);
                fail_count++;
            end else begin
                exp_w = digest_words_due.pop_front();
                if (m_tdata !== exp_w.word || m_tlast !== exp_w.last) begin
                    if (fail_count < 10)
                        $display("digest mismatch: expected %h last %b, got %h last %b",
                                 exp_w.word, exp_w.last, m_tdata, m_tlast);
                    fail_count++;
                end
            end
            if (m_tlast) digests_done <= digests_done + 1;
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------- end of run ----------------
    initial begin
        @(posedge aresetn);
        @(negedge aclk);
        while (stim_q.size() != 0 || s_tvalid || digest_words_due.size() != 0)
            @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
        $display("covered %0d messages: %0d bytes, %0d empty finishes, %0d idle words",
                 msg_count, byte_count, empty_finish, idle_count);
        $display("%0d digest words compared, %0d failures, one %0d-cycle output hold",
                 words_checked, fail_count, LONG_HOLD);
        if (fail_count == 0 && digest_words_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
